[rtl/core/bandlimited_triangle_additive_osc_core_assert.svh]
// Assertion macros shared by the oscillator core RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef BANDLIMITED_TRIANGLE_ADDITIVE_OSC_CORE_ASSERT_SVH
`define BANDLIMITED_TRIANGLE_ADDITIVE_OSC_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BTAO_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define BTAO_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/btao_pkg.sv]
// Shared types, constants and cosine table math for the oscillator core.
// No dependencies; imported by every module of the core.
package btao_pkg;

    localparam int MAX_HARMONICS_DEF  = 15;
    localparam int COS_TABLE_BITS_DEF = 10;

    localparam int PHASE_W   = 32;
    localparam int AMP_W     = 23;
    localparam int LIMCFG_W  = 4;
    localparam int COS_W     = 24;              // Q1.23, entry 0 is 2^23
    localparam int PROD_W    = AMP_W + COS_W;
    localparam int DIV_BITS  = 4;               // quotient bits per cycle
    localparam int DIV_W     = ((PROD_W + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
    localparam int ACC_W     = 49;              // sum stays below 1.24 * 2^46
    localparam int KSTEP_W   = 34;
    localparam int PCM_W     = 24;
    localparam int FRAC_SHIFT = 23;

    localparam logic [PHASE_W-1:0]  PHASE_STEP_RESET = 32'd24347887;
    localparam logic [AMP_W-1:0]    AMPLITUDE_RESET  = 23'd2097152;
    localparam logic [LIMCFG_W-1:0] HLIMIT_RESET     = 4'd15;

    localparam logic [PCM_W-1:0] PCM_MAX = 24'h7FFFFF;
    localparam logic [PCM_W-1:0] PCM_MIN = 24'h800000;

    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [1:0] {
        REG_PHASE_STEP     = 2'd0,
        REG_AMPLITUDE      = 2'd1,
        REG_HARMONIC_LIMIT = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_DIV,
        ST_FINISH
    } state_t;

    // cos(x), x in Q2.30 over [0, pi/2], Horner form of the Taylor series
    function automatic logic [63:0] cos_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] q;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        q = ((x2 * t) >> 30) / 240; t = (q > Q30_ONE) ? 64'd0 : Q30_ONE - q;
        q = ((x2 * t) >> 30) / 182; t = (q > Q30_ONE) ? 64'd0 : Q30_ONE - q;
        q = ((x2 * t) >> 30) / 132; t = (q > Q30_ONE) ? 64'd0 : Q30_ONE - q;
        q = ((x2 * t) >> 30) / 90;  t = (q > Q30_ONE) ? 64'd0 : Q30_ONE - q;
        q = ((x2 * t) >> 30) / 56;  t = (q > Q30_ONE) ? 64'd0 : Q30_ONE - q;
        q = ((x2 * t) >> 30) / 30;  t = (q > Q30_ONE) ? 64'd0 : Q30_ONE - q;
        q = ((x2 * t) >> 30) / 12;  t = (q > Q30_ONE) ? 64'd0 : Q30_ONE - q;
        q = ((x2 * t) >> 30) / 2;   t = (q > Q30_ONE) ? 64'd0 : Q30_ONE - q;
        return t;
    endfunction

    // quarter-wave table entry j of a 2^bits table, Q1.23 rounded half up
    function automatic logic [COS_W-1:0] cos_entry(input int unsigned j,
                                                   input int unsigned bits);
        logic [63:0] x;
        logic [63:0] c;
        x = (HALF_PI_Q30 * 64'(j)) >> bits;
        c = cos_q30(x);
        return COS_W'((c + 64'd64) >> 7);
    endfunction

endpackage

[rtl/core/btao_cos_rom.sv]
// Quarter-wave cosine ROM with registered read.
// Depends on btao_pkg (cos_entry builds the contents at elaboration).
module btao_cos_rom
    import btao_pkg::*;
#(
    parameter int ADDR_W = COS_TABLE_BITS_DEF
) (
    input  logic              aclk,
    input  logic [ADDR_W-1:0] addr,
    output logic [COS_W-1:0]  data
);

    localparam int DEPTH = 1 << ADDR_W;

    typedef logic [COS_W-1:0] rom_array_t [DEPTH];

    function automatic rom_array_t build_table();
        rom_array_t t;
        for (int j = 0; j < DEPTH; j++) begin
            t[j] = cos_entry(j, ADDR_W);
        end
        return t;
    endfunction

    localparam rom_array_t ROM_DATA = build_table();

    logic [COS_W-1:0] data_reg;

    always_ff @(posedge aclk) begin
        data_reg <= ROM_DATA[addr];
    end

    assign data = data_reg;

endmodule

[rtl/core/btao_divider.sv]
// Iterative unsigned restoring divider, several quotient bits per cycle.
// Depends on btao_pkg and the assertion macro header.
`include "bandlimited_triangle_additive_osc_core_assert.svh"

module btao_divider
    import btao_pkg::*;
#(
    parameter int DIVIDEND_W     = DIV_W,
    parameter int DIVISOR_W      = 10,
    parameter int BITS_PER_CYCLE = DIV_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int STEPS = DIVIDEND_W / BITS_PER_CYCLE;
    localparam int CNT_W = $clog2(STEPS + 1);
    localparam int REM_W = DIVISOR_W + 1;

    logic [DIVIDEND_W-1:0] dq_reg,  dq_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  d_reg;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [REM_W-1:0]      rem_v;
    logic [DIVIDEND_W-1:0] dq_v;

    // dividend shifts out at the top, quotient bits shift in at the bottom
    always_comb begin
        rem_v = {1'b0, rem_reg};
        dq_v  = dq_reg;
        for (int b = 0; b < BITS_PER_CYCLE; b++) begin
            rem_v = {rem_v[DIVISOR_W-1:0], dq_v[DIVIDEND_W-1]};
            dq_v  = dq_v << 1;
            if (rem_v >= {1'b0, d_reg}) begin
                rem_v   = rem_v - {1'b0, d_reg};
                dq_v[0] = 1'b1;
            end
        end
    end

    always_comb begin
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            dq_next   = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(STEPS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dq_next  = dq_v;
            rem_next = rem_v[DIVISOR_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        if (start) begin
            d_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

    `BTAO_ASSERT_IMPLIES(a_start_when_free, aclk, aresetn, start, !busy_reg && !done_reg, "divider restarted while busy")
    `BTAO_ASSERT_NEXT(a_done_after_last, aclk, aresetn, busy_reg && cnt_reg == CNT_W'(1), done_reg && !busy_reg, "divider missed its done pulse")
    `BTAO_ASSERT_IMPLIES(a_cnt_live, aclk, aresetn, busy_reg, cnt_reg != '0, "divider busy with empty count")

endmodule

[rtl/core/bandlimited_triangle_additive_osc_core.sv]
// Top level of the band-limited triangle oscillator: sequencer, datapath,
// stream and APB ports. Depends on btao_pkg, btao_cos_rom, btao_divider.
//
//  port group | dir | handshake          | word contents
//  -----------+-----+--------------------+------------------------------------
//  s_*        | in  | s_tvalid/s_tready  | tdata[0] restart
//  m_*        | out | m_tvalid/m_tready  | tdata[23:0] sample, tuser[0] clipped
//  APB        | in  | psel/penable       | 0x0 phase_step, 0x4 amplitude,
//             |     |                    | 0x8 harmonic_limit
//
// Per word the sequencer sums N odd harmonics, N being set by the limit and
// Nyquist. Each harmonic is one ROM read, one 23x24 multiply and a pass
// through the shared 4-bit-per-cycle divider (by k^2).
// s_tready is high only while the sequencer is idle.
// Reset: synchronous, active low; phase accumulator cleared, registers to
// their defaults. A result waiting in the output register stalls the final
// write-back, so the next input word waits too (s_tready stays low).
`include "bandlimited_triangle_additive_osc_core_assert.svh"

module bandlimited_triangle_additive_osc_core
    import btao_pkg::*;
#(
    parameter int MAX_HARMONICS  = MAX_HARMONICS_DEF,
    parameter int COS_TABLE_BITS = COS_TABLE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [0] restart, [7:1] zero
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [23:0] sample (signed PCM)
    output logic [0:0]  m_tuser,    // [0] clipped
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int K_W    = $clog2(2 * MAX_HARMONICS);   // odd harmonic number
    localparam int KSQ_W  = 2 * K_W;                     // its square
    localparam int LIM_W  = $clog2(MAX_HARMONICS + 1);
    localparam int ADDR_W = COS_TABLE_BITS;
    localparam int SUM_W  = ACC_W + 1;
    localparam int SHR_W  = SUM_W - FRAC_SHIFT;

    localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_SHIFT - 1);

    // configuration
    logic [PHASE_W-1:0]  phase_step_reg;
    logic [AMP_W-1:0]    amplitude_reg;
    logic [LIMCFG_W-1:0] harmonic_limit_reg;

    // control
    state_t              state_reg,     state_next;
    logic [PHASE_W-1:0]  phase_acc_reg, phase_acc_next;
    logic                m_tvalid_reg,  m_tvalid_next;

    // datapath
    logic [PHASE_W-1:0]  phase_reg,   phase_next;    // base phase of this word
    logic [PHASE_W-1:0]  p_reg,       p_next;        // k * phase mod 2^32
    logic [KSTEP_W-1:0]  kstep_reg,   kstep_next;    // k * phase_step
    logic [K_W-1:0]      k_reg,       k_next;
    logic [KSQ_W-1:0]    ksq_reg,     ksq_next;
    logic [LIM_W-1:0]    cnt_reg,     cnt_next;
    logic [LIM_W-1:0]    limit_reg,   limit_next;
    logic [ACC_W-1:0]    acc_reg,     acc_next;
    logic                cos_neg_reg, cos_neg_next;
    logic                cos_zero_reg, cos_zero_next;
    logic [PCM_W-1:0]    sample_reg,  sample_next;
    logic                clipped_reg, clipped_next;

    // ROM address, quadrant handling
    logic [1:0]          quad;
    logic [ADDR_W-1:0]   idx;
    logic [ADDR_W-1:0]   rom_addr;
    logic [COS_W-1:0]    rom_data;
    logic [COS_W-1:0]    cos_mag;

    // multiply / divide
    logic [PROD_W-1:0]   prod;
    logic                div_start;
    logic                div_done;
    logic [DIV_W-1:0]    div_quotient;
    logic [ACC_W-1:0]    term;

    // rounding and saturation
    logic [SUM_W-1:0]    rsum;
    logic [SHR_W-1:0]    shr;
    logic                in_range;

    logic                cfg_wr;
    logic [LIM_W-1:0]    limit_eff;

    //--------------------------------------------------------------------
    // APB register file
    //--------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg     <= PHASE_STEP_RESET;
            amplitude_reg      <= AMPLITUDE_RESET;
            harmonic_limit_reg <= HLIMIT_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx_t'(paddr[3:2]))
                REG_PHASE_STEP:     phase_step_reg     <= pwdata;
                REG_AMPLITUDE:      amplitude_reg      <= pwdata[AMP_W-1:0];
                REG_HARMONIC_LIMIT: harmonic_limit_reg <= pwdata[LIMCFG_W-1:0];
                default: ;  // unmapped, ignored
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_PHASE_STEP:     prdata = phase_step_reg;
            REG_AMPLITUDE:      prdata = {{(32-AMP_W){1'b0}}, amplitude_reg};
            REG_HARMONIC_LIMIT: prdata = {{(32-LIMCFG_W){1'b0}}, harmonic_limit_reg};
            default:            prdata = '0;
        endcase
    end

    // harmonic count clamped to what the build supports
    always_comb begin
        if (int'(harmonic_limit_reg) > MAX_HARMONICS) begin
            limit_eff = LIM_W'(MAX_HARMONICS);
        end else begin
            limit_eff = LIM_W'(harmonic_limit_reg);
        end
    end

    //--------------------------------------------------------------------
    // Cosine lookup: quadrant in p[31:30], index below it (truncated).
    // Odd quadrants read the mirrored index; mirror of 0 is cos(pi/2) = 0.
    //--------------------------------------------------------------------
    assign quad     = p_reg[PHASE_W-1 -: 2];
    assign idx      = p_reg[PHASE_W-3 -: ADDR_W];
    assign rom_addr = quad[0] ? (ADDR_W'(0) - idx) : idx;

    btao_cos_rom #(
        .ADDR_W (ADDR_W)
    ) u_cos_rom (
        .aclk (aclk),
        .addr (rom_addr),
        .data (rom_data)
    );

    assign cos_mag = cos_zero_reg ? '0 : rom_data;
    assign prod    = PROD_W'(amplitude_reg) * PROD_W'(cos_mag);

    // shared divider: |amplitude * cos| / k^2, sign applied afterwards
    btao_divider #(
        .DIVIDEND_W     (DIV_W),
        .DIVISOR_W      (KSQ_W),
        .BITS_PER_CYCLE (DIV_BITS)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (DIV_W'(prod)),
        .divisor  (ksq_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb begin
        term = {{(ACC_W-DIV_W){1'b0}}, div_quotient};
        if (cos_neg_reg) begin
            term = ACC_W'(0) - term;   // truncation toward zero kept
        end
    end

    // Q.46 -> Q.23, round half up, then clamp to 24 bits
    assign rsum     = {acc_reg[ACC_W-1], acc_reg} + ROUND_HALF;
    assign shr      = rsum[SUM_W-1:FRAC_SHIFT];
    assign in_range = (&shr[SHR_W-1:PCM_W-1]) | ~(|shr[SHR_W-1:PCM_W-1]);

    //--------------------------------------------------------------------
    // Sequencer
    //--------------------------------------------------------------------
    always_comb begin
        state_next     = state_reg;
        phase_acc_next = phase_acc_reg;
        m_tvalid_next  = m_tvalid_reg;
        phase_next     = phase_reg;
        p_next         = p_reg;
        kstep_next     = kstep_reg;
        k_next         = k_reg;
        ksq_next       = ksq_reg;
        cnt_next       = cnt_reg;
        limit_next     = limit_reg;
        acc_next       = acc_reg;
        cos_neg_next   = cos_neg_reg;
        cos_zero_next  = cos_zero_reg;
        sample_next    = sample_reg;
        clipped_next   = clipped_reg;
        div_start      = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    phase_next = s_tdata[0] ? '0 : phase_acc_reg;
                    p_next     = s_tdata[0] ? '0 : phase_acc_reg;
                    kstep_next = KSTEP_W'(phase_step_reg);
                    k_next     = K_W'(1);
                    ksq_next   = KSQ_W'(1);
                    cnt_next   = '0;
                    limit_next = limit_eff;
                    acc_next   = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // ROM read is issued here; its flags travel alongside
                cos_neg_next  = quad[1] ^ quad[0];
                cos_zero_next = quad[0] && (idx == '0);
                // k*step grows with k, so the first harmonic past Nyquist ends the sum
                if (cnt_reg == limit_reg || kstep_reg[KSTEP_W-1:PHASE_W-1] != '0) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    acc_next   = acc_reg + term;
                    cnt_next   = cnt_reg + LIM_W'(1);
                    k_next     = k_reg + K_W'(2);
                    // (k+2)^2 = k^2 + 4k + 4
                    ksq_next   = ksq_reg + KSQ_W'({k_reg, 2'b00}) + KSQ_W'(4);
                    p_next     = p_reg + {phase_reg[PHASE_W-2:0], 1'b0};
                    kstep_next = kstep_reg + KSTEP_W'({phase_step_reg, 1'b0});
                    state_next = ST_CHECK;
                end
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    if (in_range) begin
                        sample_next = shr[PCM_W-1:0];
                    end else begin
                        sample_next = shr[SHR_W-1] ? PCM_MIN : PCM_MAX;
                    end
                    clipped_next   = !in_range;
                    m_tvalid_next  = 1'b1;
                    phase_acc_next = phase_reg + phase_step_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_acc_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_acc_reg <= phase_acc_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        phase_reg    <= phase_next;
        p_reg        <= p_next;
        kstep_reg    <= kstep_next;
        k_reg        <= k_next;
        ksq_reg      <= ksq_next;
        cnt_reg      <= cnt_next;
        limit_reg    <= limit_next;
        acc_reg      <= acc_next;
        cos_neg_reg  <= cos_neg_next;
        cos_zero_reg <= cos_zero_next;
        sample_reg   <= sample_next;
        clipped_reg  <= clipped_next;
    end

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = sample_reg;
    assign m_tuser[0] = clipped_reg;

    `BTAO_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input accepted twice in a row")
    `BTAO_ASSERT_IMPLIES(a_done_in_div, aclk, aresetn, div_done, state_reg == ST_DIV, "divider result outside divide state")
    `BTAO_ASSERT_IMPLIES(a_cnt_bound, aclk, aresetn, state_reg != ST_IDLE, cnt_reg <= limit_reg, "harmonic count past limit")
    `BTAO_ASSERT_NEXT(a_phase_hold, aclk, aresetn, state_reg != ST_FINISH, $stable(phase_acc_reg), "phase moved outside write-back")

endmodule

[test/tb_bandlimited_triangle_additive_osc_core.sv]
// Self-checking testbench for the band-limited triangle oscillator core.
// Needs btao_pkg and the core RTL; predicts every PCM word with its own
// fixed-point model of the additive sum and checks it field by field.
`timescale 1ns / 1ps

module tb_bandlimited_triangle_additive_osc_core;
    import btao_pkg::*;

    // ------------------------------------------------------------------
    // Constants
    // ------------------------------------------------------------------
    localparam int          COS_BITS         = COS_TABLE_BITS_DEF;
    localparam int          COS_ENTRIES      = 1 << COS_BITS;
    localparam logic [63:0] NYQUIST_PHASE    = 64'd1 << 31;   // half a turn
    localparam longint      ROUND_HALF       = 64'sd4194304;  // 2^22, half an LSB of Q.23
    localparam logic [3:0]  UNMAPPED_ADDR    = 4'hC;          // no register here
    localparam int          SINK_HOLD_CYCLES = 600;           // > two full 15-harmonic words
    localparam int          TAIL_CYCLES      = 300;           // longer than the worst word (15 harmonics)
    localparam int          RANDOM_WORDS     = 1000;

    typedef struct packed {
        logic [PCM_W-1:0] sample;
        logic             clipped;
    } pcm_word_t;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;      // [0] restart, [7:1] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;      // [23:0] sample (signed PCM)
    logic [0:0]  m_tuser;      // [0] clipped
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bandlimited_triangle_additive_osc_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the registers and the phase.
    // Reset happens once at time zero, so the initializers are the reset.
    // ------------------------------------------------------------------
    logic [PHASE_W-1:0]  cfg_step  = PHASE_STEP_RESET;
    logic [AMP_W-1:0]    cfg_amp   = AMPLITUDE_RESET;
    logic [LIMCFG_W-1:0] cfg_limit = HLIMIT_RESET;
    logic [PHASE_W-1:0]  osc_phase = '0;
    logic [COS_W-1:0]    quarter_cos [0:COS_ENTRIES-1];

    pcm_word_t pcm_expected_q[$];
    int        mismatch_count = 0;

    // idling controls
    bit src_idle_on   = 1'b1;     // sender draws gaps (tests write it with =)
    bit sink_idle_on  = 1'b1;     // receiver draws gaps (tests write it with <=)
    int sink_hold_req = 0;        // bump to ask the receiver for one long hold

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Quarter-wave cosine table: Taylor series to x^16 in Q2.30, Horner form,
    // then rounded half up to Q1.23.
    initial begin : build_cos_table
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] q;
        for (int j = 0; j < COS_ENTRIES; j++) begin
            x  = (HALF_PI_Q30 * 64'(j)) >> COS_BITS;
            x2 = (x * x) >> 30;
            t  = Q30_ONE;
            for (int m = 8; m >= 1; m--) begin
                q = ((x2 * t) >> 30) / 64'((2 * m - 1) * (2 * m));
                t = (q > Q30_ONE) ? 64'd0 : Q30_ONE - q;
            end
            quarter_cos[j] = COS_W'((t + 64'd64) >> 7);
        end
    end

    // ------------------------------------------------------------------
    // Predictor: one input word -> one PCM word, advances the phase
    // ------------------------------------------------------------------
    function automatic pcm_word_t predict_pcm_word(input logic restart);
        longint          acc;
        longint          amp;
        longint          cosv;
        longint          mirror;
        longint          s;
        logic [63:0]     k;
        logic [63:0]     kphase;
        logic [31:0]     p;
        logic [COS_BITS-1:0] idx;
        int              lim;
        pcm_word_t       w;

        if (restart)
            osc_phase = '0;
        lim = (cfg_limit > MAX_HARMONICS_DEF) ? MAX_HARMONICS_DEF : int'(cfg_limit);
        acc = 0;
        amp = longint'(cfg_amp);

        for (int i = 1; i <= lim; i++) begin
            k = 64'(2 * i - 1);
            // harmonic only while k*step stays under Nyquist
            if (k * 64'(cfg_step) < NYQUIST_PHASE) begin
                kphase = k * 64'(osc_phase);
                p      = kphase[31:0];
                idx    = p[29 -: COS_BITS];
                // mirrored index of zero lands on cos(pi/2) = 0
                mirror = (idx == 0) ? 64'sd0 : longint'(quarter_cos[COS_ENTRIES - idx]);
                case (p[31:30])
                    2'd0:    cosv = longint'(quarter_cos[idx]);
                    2'd1:    cosv = -mirror;
                    2'd2:    cosv = -longint'(quarter_cos[idx]);
                    default: cosv = mirror;
                endcase
                acc += (amp * cosv) / longint'(k * k);   // truncates toward zero
            end
        end

        // Q.46 -> Q.23, round half up, then saturate
        s = (acc + ROUND_HALF) >>> 23;
        w.clipped = 1'b0;
        if (s > 8388607) begin
            s = 8388607;
            w.clipped = 1'b1;
        end else if (s < -8388608) begin
            s = -8388608;
            w.clipped = 1'b1;
        end
        w.sample = s[PCM_W-1:0];

        osc_phase += cfg_step;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Shared stimulus tasks
    // ------------------------------------------------------------------

    // One APB transfer: setup cycle, then access until pready.
    task automatic apb_access(input logic wr, input logic [3:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Register write plus the matching update of the predictor's copy.
    task automatic set_reg(input reg_idx_t idx, input logic [31:0] value);
        logic [31:0] unused;
        apb_access(1'b1, {idx, 2'b00}, value, unused);
        case (idx)
            REG_PHASE_STEP:     cfg_step  = value;
            REG_AMPLITUDE:      cfg_amp   = value[AMP_W-1:0];
            REG_HARMONIC_LIMIT: cfg_limit = value[LIMCFG_W-1:0];
            default: ;
        endcase
    endtask

    // Read back every register and compare with the predictor's copy.
    task automatic check_all_regs();
        reg_idx_t    idx;
        logic [31:0] rd;
        logic [31:0] want;
        idx = idx.first();
        do begin
            case (idx)
                REG_PHASE_STEP:     want = cfg_step;
                REG_AMPLITUDE:      want = 32'(cfg_amp);
                default:            want = 32'(cfg_limit);
            endcase
            apb_access(1'b0, {idx, 2'b00}, 32'd0, rd);
            if (rd !== want) begin
                $display("%0t: register %s readback: expected %h, actual %h",
                         $time, idx.name(), want, rd);
                mismatch_count++;
            end
            idx = idx.next();
        end while (idx != idx.first());
    endtask

    // Offer one input word after a random gap; predict it once accepted.
    // valid is only dropped when a gap follows, so back-to-back words keep
    // it high without a second assignment in the same step.
    task automatic send_word(input logic restart);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {7'b0, 1'($urandom())};   // junk while not valid
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, restart};
        do @(posedge aclk); while (!s_tready);
        pcm_expected_q.push_back(predict_pcm_word(restart));
    endtask

    // Stop offering and wait until every predicted word has come back.
    // Each word yields exactly one result, so the core is idle afterwards.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pcm_expected_q.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random gap after each word, plus long holds on request.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int gap_left;
        int hold_left;
        int holds_seen;
        gap_left   = 0;
        hold_left  = 0;
        holds_seen = 0;
        m_tready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (holds_seen != sink_hold_req) begin
                holds_seen = sink_hold_req;
                hold_left  = SINK_HOLD_CYCLES;
            end
            if (m_tvalid && m_tready)
                gap_left = sink_idle_on ? $urandom_range(0, 4) : 0;
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted word against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : check_pcm
        pcm_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pcm_expected_q.size() == 0) begin
                $display("%0t: unexpected word: expected none, actual sample %0d clipped %0b",
                         $time, $signed(m_tdata), m_tuser[0]);
                mismatch_count++;
            end else begin
                want = pcm_expected_q.pop_front();
                if (m_tdata !== want.sample) begin
                    $display("%0t: sample mismatch: expected %0d, actual %0d",
                             $time, $signed(want.sample), $signed(m_tdata));
                    mismatch_count++;
                end
                if (m_tuser[0] !== want.clipped) begin
                    $display("%0t: clipped mismatch: expected %0b, actual %0b",
                             $time, want.clipped, m_tuser[0]);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Defaults after reset, masking of over-wide writes, unmapped address.
    task automatic test_register_access();
        logic [31:0] unused;
        check_all_regs();
        set_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
        set_reg(REG_AMPLITUDE, 32'hFFFF_FFFF);       // only 23 bits stick
        set_reg(REG_HARMONIC_LIMIT, 32'hFFFF_FFFF);  // only 4 bits stick
        check_all_regs();
        apb_access(1'b1, UNMAPPED_ADDR, $urandom(), unused);
        check_all_regs();
        set_reg(REG_PHASE_STEP, 32'(PHASE_STEP_RESET));
        set_reg(REG_AMPLITUDE, 32'(AMPLITUDE_RESET));
        set_reg(REG_HARMONIC_LIMIT, 32'(HLIMIT_RESET));
        check_all_regs();
    endtask

    // Short directed list: field extremes and the named corner cases.
    task automatic test_directed_corners();
        logic [31:0] unused;
        // reset settings from phase zero; restart mid-run
        send_word(1'b0);
        send_word(1'b0);
        send_word(1'b1);
        wait_for_results();

        // DC at full scale: sum of 1/k^2 exceeds 1, clips high
        set_reg(REG_AMPLITUDE, 32'hFFFF_FFFF);
        set_reg(REG_PHASE_STEP, 32'd0);
        set_reg(REG_HARMONIC_LIMIT, 32'hFFFF_FFFF);
        send_word(1'b1);
        wait_for_results();

        // quarter-turn step: fundamental only, hits the quadrant edges
        set_reg(REG_PHASE_STEP, 32'h4000_0000);
        send_word(1'b1);
        send_word(1'b0);
        wait_for_results();
        // phase parked at half a turn, all harmonics at -1: clips low
        set_reg(REG_PHASE_STEP, 32'd0);
        send_word(1'b0);
        wait_for_results();

        // harmonic limit zero: silence
        set_reg(REG_HARMONIC_LIMIT, 32'd0);
        send_word(1'b0);
        wait_for_results();

        // one harmonic, step just under Nyquist
        set_reg(REG_HARMONIC_LIMIT, 32'd1);
        set_reg(REG_PHASE_STEP, 32'h7FFF_FFFF);
        send_word(1'b1);
        send_word(1'b0);
        wait_for_results();

        // step at Nyquist and at the top: even the fundamental drops out
        set_reg(REG_HARMONIC_LIMIT, 32'd15);
        set_reg(REG_PHASE_STEP, 32'h8000_0000);
        send_word(1'b0);
        wait_for_results();
        set_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
        send_word(1'b0);
        wait_for_results();

        // write to an unmapped address must not disturb anything
        set_reg(REG_PHASE_STEP, 32'(PHASE_STEP_RESET));
        apb_access(1'b1, UNMAPPED_ADDR, $urandom(), unused);
        send_word(1'b0);
        wait_for_results();

        // zero gain
        set_reg(REG_AMPLITUDE, 32'd0);
        send_word(1'b0);
        wait_for_results();

        // 29*step right below / right above Nyquist: top harmonic in or out
        set_reg(REG_AMPLITUDE, 32'h007F_FFFF);
        set_reg(REG_PHASE_STEP, 32'd74051160);
        send_word(1'b1);
        send_word(1'b0);
        wait_for_results();
        set_reg(REG_PHASE_STEP, 32'd74051161);
        send_word(1'b1);
        send_word(1'b0);
        wait_for_results();
    endtask

    // Receiver holds off long enough for the core to fill and stall s_tready.
    task automatic test_output_backpressure();
        set_reg(REG_PHASE_STEP, 32'(PHASE_STEP_RESET));
        set_reg(REG_AMPLITUDE, 32'(AMPLITUDE_RESET));
        set_reg(REG_HARMONIC_LIMIT, 32'd15);         // slowest words
        sink_hold_req <= sink_hold_req + 1;
        repeat (6) send_word(1'($urandom()));
        wait_for_results();
    endtask

    // No idling on either side, with a full drain halfway.
    task automatic test_drain_pause();
        src_idle_on = 1'b0;
        sink_idle_on <= 1'b0;
        set_reg(REG_PHASE_STEP, $urandom_range(0, 32'd74051160));
        repeat (10) send_word($urandom_range(0, 7) == 0);
        wait_for_results();
        repeat (10) send_word($urandom_range(0, 7) == 0);
        wait_for_results();
        src_idle_on = 1'b1;
        sink_idle_on <= 1'b1;
    endtask

    // Random settings per phase, random words in between.
    task automatic test_random_sweep();
        int          sent;
        int          n;
        int          pick;
        int unsigned k;
        logic [31:0] step;
        logic [31:0] amp;
        logic [31:0] lim;
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                step = $urandom_range(0, 32'd74051160);   // every harmonic audible
            end else if (pick < 7) begin
                k    = 2 * $urandom_range(1, 15) - 1;     // around a Nyquist edge
                step = 32'h8000_0000 / k + $urandom_range(0, 2) - 1;
            end else if (pick == 7) begin
                step = $urandom();
            end else if (pick == 8) begin
                step = $urandom_range(0, 255);
            end else begin
                case ($urandom_range(0, 3))
                    0:       step = 32'd0;
                    1:       step = 32'h7FFF_FFFF;
                    2:       step = 32'h8000_0000;
                    default: step = 32'hFFFF_FFFF;
                endcase
            end
            case ($urandom_range(0, 3))
                0:       amp = 32'h007F_FFFF;
                1:       amp = $urandom();                 // upper bits dropped
                2:       amp = $urandom_range(0, 32'h1F_FFFF);
                default: amp = $urandom_range(0, 32'h7F_FFFF);
            endcase
            lim = ($urandom() & 32'hFFFF_FFF0)
                | (($urandom_range(0, 2) == 0) ? 32'd15 : $urandom_range(0, 15));

            set_reg(REG_PHASE_STEP, step);
            set_reg(REG_AMPLITUDE, amp);
            set_reg(REG_HARMONIC_LIMIT, lim);

            src_idle_on = ($urandom_range(0, 3) != 0);
            sink_idle_on <= ($urandom_range(0, 3) != 0);
            n = $urandom_range(20, 60);
            send_word(1'($urandom_range(0, 1)));
            repeat (n - 1) send_word($urandom_range(0, 11) == 0);
            wait_for_results();
            sent += n;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'd0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = 4'd0;
        pwdata   = 32'd0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_register_access();
        test_directed_corners();
        test_output_backpressure();
        test_drain_pause();
        test_random_sweep();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);   // catch any stray extra word
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog: several times the slowest correct run.
    initial begin
        #15_000_000;
        $display("%0t: timeout, %0d words still expected", $time, pcm_expected_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
